// ===== sv/zac_pkg.sv =====
// Shared types, constants and lookup functions for the autoconfig chain responder.
package zac_pkg;

    localparam int MAX_BOARDS  = 8;
    localparam int SLOT_W      = 3;
    localparam int ROM_NIBBLES = 24;

    // Bus offsets in the autoconfig window
    localparam logic [15:0] ADDR_BASE_LO = 16'h004A;
    localparam logic [15:0] ADDR_BASE_HI = 16'h0048;
    localparam logic [15:0] ADDR_SHUTUP  = 16'h004C;
    localparam logic [15:0] ADDR_TRUE_0  = 16'h0000;
    localparam logic [15:0] ADDR_TRUE_1  = 16'h0002;
    localparam logic [15:0] ADDR_TRUE_2  = 16'h0040;
    localparam logic [15:0] ADDR_TRUE_3  = 16'h0042;

    localparam logic [3:0] LINK_FLAG = 4'h8;

    // Identity ROMs, nibble n at bits [4n+3:4n]
    localparam logic [95:0] ROM_FASTRAM = 96'h00000240_00000000_0008960E;
    localparam logic [95:0] ROM_BRIDGE  = 96'h00000000_413ABD70_00003A1C;
    localparam logic [95:0] ROM_DISK    = 96'h00041240_00000000_0000A61D;
    localparam logic [95:0] ROM_DEVICE  = 96'h00042240_00000000_0000B61C;

    typedef enum logic [2:0] {
        KIND_NONE    = 3'd0,
        KIND_FASTRAM = 3'd1,
        KIND_BRIDGE  = 3'd2,
        KIND_DISK    = 3'd3,
        KIND_DEVICE  = 3'd4
    } t_kind;

    typedef enum logic [1:0] {
        CFG_BOARD_COUNT = 2'd0,
        CFG_BOARD_KINDS = 2'd1,
        CFG_RAM_SIZES   = 2'd2,
        CFG_MFR_ID      = 2'd3
    } t_cfg_idx;

    typedef struct packed {
        logic [3:0]  board_count;
        logic [23:0] board_kinds;
        logic [15:0] ram_size_codes;
        logic [15:0] manufacturer_id;
    } t_cfg;

    typedef struct packed {
        logic        mode;
        logic [15:0] bus_address;
        logic [7:0]  write_byte;
    } t_item;

    typedef struct packed {
        logic        chain_complete;
        logic [23:0] finished_base;
        logic [2:0]  finished_slot;
        logic        board_finished;
        logic [7:0]  read_byte;
    } t_result;

    function automatic t_kind decode_kind(input logic [2:0] raw);
        t_kind k;
        case (raw)
            3'd1:    k = KIND_FASTRAM;
            3'd2:    k = KIND_BRIDGE;
            3'd3:    k = KIND_DISK;
            3'd4:    k = KIND_DEVICE;
            default: k = KIND_NONE;
        endcase
        return k;
    endfunction

    function automatic logic [3:0] size_nibble(input logic [1:0] code);
        logic [3:0] nib;
        case (code)
            2'd0:    nib = 4'h1;
            2'd1:    nib = 4'h6;
            2'd2:    nib = 4'h7;
            default: nib = 4'h0;
        endcase
        return nib;
    endfunction

    function automatic logic [3:0] rom_nibble(input t_kind kind, input logic [4:0] n);
        logic [95:0] vec;
        logic [95:0] sh;
        case (kind)
            KIND_FASTRAM: vec = ROM_FASTRAM;
            KIND_BRIDGE:  vec = ROM_BRIDGE;
            KIND_DISK:    vec = ROM_DISK;
            KIND_DEVICE:  vec = ROM_DEVICE;
            default:      vec = '0;
        endcase
        sh = vec >> {n, 2'b00};
        return sh[3:0];
    endfunction

endpackage

// ===== sv/zac_cfg.sv =====
// Configuration register file for the autoconfig chain responder.
module zac_cfg
    import zac_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_we,
    input  logic [1:0]  i_index,
    input  logic [23:0] i_data,
    output t_cfg        o_cfg
);

    t_cfg r_cfg;
    t_cfg n_cfg;

    always_comb begin
        n_cfg = r_cfg;
        if (i_we) begin
            case (t_cfg_idx'(i_index))
                CFG_BOARD_COUNT: n_cfg.board_count     = i_data[3:0];
                CFG_BOARD_KINDS: n_cfg.board_kinds     = i_data;
                CFG_RAM_SIZES:   n_cfg.ram_size_codes  = i_data[15:0];
                CFG_MFR_ID:      n_cfg.manufacturer_id = i_data[15:0];
                default:         n_cfg = r_cfg;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg <= '0;
        end else begin
            r_cfg <= n_cfg;
        end
    end

    assign o_cfg = r_cfg;

endmodule

// ===== sv/zac_engine.sv =====
// Chain state and per-access decode: ROM reads, base writes, board completion.
module zac_engine
    import zac_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_fire,
    input  t_item   i_item,
    input  t_cfg    i_cfg,
    output t_result o_result
);

    logic [3:0]  r_slot;
    logic [3:0]  n_slot;
    logic [7:0]  r_ram_base [MAX_BOARDS];
    logic [7:0]  r_scsi_base;
    logic [7:0]  r_dev_base;

    logic [3:0]        eff_cnt;
    logic              slot_live;
    logic [SLOT_W-1:0] slot_idx;
    t_kind             kind;
    logic [23:0]       kinds_sh;
    logic [15:0]       sizes_sh;
    logic [15:0]       mfr_sh;
    logic [4:0]        nib_idx;
    logic              in_rom;
    logic [3:0]        nib;
    logic [7:0]        rd_val;
    logic              has_base;
    logic [7:0]        old_base;
    logic [7:0]        new_base;
    logic              base_we;
    logic              done;

    assign eff_cnt   = (i_cfg.board_count > 4'(MAX_BOARDS)) ? 4'(MAX_BOARDS)
                                                           : i_cfg.board_count;
    assign slot_live = r_slot < eff_cnt;
    assign slot_idx  = r_slot[SLOT_W-1:0];
    assign kinds_sh  = i_cfg.board_kinds >> (5'(slot_idx) * 5'd3);
    assign kind      = slot_live ? decode_kind(kinds_sh[2:0]) : KIND_NONE;
    assign sizes_sh  = i_cfg.ram_size_codes >> {slot_idx, 1'b0};
    assign nib_idx   = i_item.bus_address[5:1];
    assign in_rom    = !i_item.bus_address[0]
                       && (i_item.bus_address[15:1] < 15'(ROM_NIBBLES));
    assign mfr_sh    = i_cfg.manufacturer_id >> {~nib_idx[1:0], 2'b00};

    // ROM read path
    always_comb begin
        nib = 4'h0;
        if (in_rom) begin
            if (kind == KIND_FASTRAM && nib_idx == 5'd1) begin
                nib = size_nibble(sizes_sh[1:0]);
                if ((r_slot + 4'd1) < eff_cnt) begin
                    nib = nib | LINK_FLAG;
                end
            end else if (kind != KIND_BRIDGE && nib_idx >= 5'd8 && nib_idx <= 5'd11) begin
                nib = mfr_sh[3:0];
            end else begin
                nib = rom_nibble(kind, nib_idx);
            end
        end
        rd_val = {nib, 4'h0};
        if (i_item.bus_address != ADDR_TRUE_0 && i_item.bus_address != ADDR_TRUE_1
            && i_item.bus_address != ADDR_TRUE_2 && i_item.bus_address != ADDR_TRUE_3) begin
            rd_val = ~rd_val;
        end
        if (kind == KIND_NONE) begin
            rd_val = 8'h00;
        end
    end

    // Write path
    always_comb begin
        has_base = 1'b0;
        old_base = 8'h00;
        case (kind)
            KIND_FASTRAM: begin
                has_base = 1'b1;
                old_base = r_ram_base[slot_idx];
            end
            KIND_DISK: begin
                has_base = 1'b1;
                old_base = r_scsi_base;
            end
            KIND_DEVICE: begin
                has_base = 1'b1;
                old_base = r_dev_base;
            end
            default: begin
                has_base = 1'b0;
                old_base = 8'h00;
            end
        endcase

        new_base = old_base;
        base_we  = 1'b0;
        done     = 1'b0;
        if (i_item.mode && slot_live) begin
            if (!has_base) begin
                done = 1'b1;
            end else if (i_item.bus_address == ADDR_BASE_LO) begin
                new_base = {4'h0, i_item.write_byte[7:4]};
                base_we  = 1'b1;
            end else if (i_item.bus_address == ADDR_BASE_HI) begin
                new_base = {i_item.write_byte[7:4], old_base[3:0]};
                base_we  = 1'b1;
                done     = 1'b1;
            end else if (i_item.bus_address == ADDR_SHUTUP) begin
                done = 1'b1;
            end
        end
        n_slot = done ? r_slot + 4'd1 : r_slot;

        o_result.read_byte      = i_item.mode ? 8'h00 : rd_val;
        o_result.board_finished = done;
        o_result.finished_slot  = done ? slot_idx : '0;
        o_result.finished_base  = (done && has_base) ? {new_base, 16'h0000} : 24'h0;
        o_result.chain_complete = n_slot >= eff_cnt;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_slot      <= '0;
            r_scsi_base <= '0;
            r_dev_base  <= '0;
            for (int i = 0; i < MAX_BOARDS; i++) begin
                r_ram_base[i] <= '0;
            end
        end else if (i_fire) begin
            r_slot <= n_slot;
            if (base_we) begin
                case (kind)
                    KIND_FASTRAM: r_ram_base[slot_idx] <= new_base;
                    KIND_DISK:    r_scsi_base          <= new_base;
                    KIND_DEVICE:  r_dev_base           <= new_base;
                    default:      ;
                endcase
            end
        end
    end

endmodule

// ===== sv/zorro2_autoconfig_chain_core.sv =====
// Top level of the expansion-bus autoconfig responder for a chain of boards.
//
//  channel   dir  handshake                       payload
//  s_axis    in   i_s_axis_tvalid/o_s_axis_tready tdata: bus_address, write_byte; tuser: mode
//  m_axis    out  o_m_axis_tvalid/i_m_axis_tready tdata: read_byte .. chain_complete
//  cfg       in   i_cfg_valid/o_cfg_ready         i_cfg_index, i_cfg_data
//
// Each word is held in the input register, decoded, and captured in the result
// register; one word a cycle is sustained while the result side is not
// stalled, set by the single decode stage between the two.
// Synchronous active-low reset clears the chain slot, all base registers,
// the configuration and both valid flags. A stalled result register holds;
// the input register still takes a word while the result register drains.
module zorro2_autoconfig_chain_core
    import zac_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    // stream in
    input  logic        i_s_axis_tvalid,
    output logic        o_s_axis_tready,
    input  logic [23:0] i_s_axis_tdata,   // [15:0] bus_address, [23:16] write_byte
    input  logic        i_s_axis_tuser,   // [0] mode
    // stream out
    output logic        o_m_axis_tvalid,
    input  logic        i_m_axis_tready,
    output logic [39:0] o_m_axis_tdata,   // [7:0] read_byte, [8] board_finished,
                                          // [11:9] finished_slot, [35:12] finished_base,
                                          // [36] chain_complete, [39:37] zero
    // configuration writes
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [1:0]  i_cfg_index,
    input  logic [23:0] i_cfg_data
);

    t_cfg    cfg;
    t_result result;

    logic    r_in_vld;
    t_item   r_in;
    logic    r_out_vld;
    t_result r_out;

    logic    s_fire;
    logic    advance;

    // Config is always taken; the host writes only while the chain is idle
    assign o_cfg_ready = 1'b1;

    zac_cfg u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_we    (i_cfg_valid),
        .i_index (i_cfg_index),
        .i_data  (i_cfg_data),
        .o_cfg   (cfg)
    );

    // Move the held word into the result register when that slot frees up
    assign advance         = r_in_vld && (!r_out_vld || i_m_axis_tready);
    assign o_s_axis_tready = !r_in_vld || advance;
    assign s_fire          = i_s_axis_tvalid && o_s_axis_tready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_vld <= 1'b0;
        end else if (o_s_axis_tready) begin
            r_in_vld <= i_s_axis_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_fire) begin
            r_in.mode        <= i_s_axis_tuser;
            r_in.bus_address <= i_s_axis_tdata[15:0];
            r_in.write_byte  <= i_s_axis_tdata[23:16];
        end
    end

    // Decode and update chain state as the word advances
    zac_engine u_engine (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_fire   (advance),
        .i_item   (r_in),
        .i_cfg    (cfg),
        .o_result (result)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (advance) begin
            r_out_vld <= 1'b1;
        end else if (i_m_axis_tready) begin
            r_out_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance) begin
            r_out <= result;
        end
    end

    assign o_m_axis_tvalid = r_out_vld;
    assign o_m_axis_tdata  = {3'b000, r_out};

    // A write never returns read data
    a_write_no_data: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        advance && r_in.mode |-> result.read_byte == 8'h00)
        else $error("write produced read data");

    // Only a write can finish a board
    a_finish_on_write: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        advance && result.board_finished |-> r_in.mode)
        else $error("board finished on a read");

    // No finish means empty slot and base fields
    a_idle_fields: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_vld && !r_out.board_finished |->
            r_out.finished_slot == 3'd0 && r_out.finished_base == 24'h0)
        else $error("finish fields set without a finish");

    // Base addresses are 64KB aligned
    a_base_aligned: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_vld |-> r_out.finished_base[15:0] == 16'h0000)
        else $error("unaligned base reported");

    // Input register accepts whenever it is empty
    a_take_when_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_in_vld |-> o_s_axis_tready)
        else $error("input stage stalled while empty");

endmodule

// ===== tb/tb.sv =====
// Self-checking testbench for the autoconfig chain responder core.
`timescale 1ns / 100ps

module tb;
    import zac_pkg::*;

    localparam logic MODE_READ  = 1'b0;
    localparam logic MODE_WRITE = 1'b1;

    // Size codes held two bits per slot in the size register
    localparam logic [1:0] SIZE_64K = 2'd0;
    localparam logic [1:0] SIZE_2M  = 2'd1;
    localparam logic [1:0] SIZE_4M  = 2'd2;
    localparam logic [1:0] SIZE_8M  = 2'd3;

    // Identity nibbles per board kind, nibble 0 first
    localparam logic [0:23][3:0] FASTRAM_ID = 96'hE06980000000_000004200000;
    localparam logic [0:23][3:0] BRIDGE_ID  = 96'hC1A3000007DB_A31400000000;
    localparam logic [0:23][3:0] DISK_ID    = 96'hD16A00000000_000004214000;
    localparam logic [0:23][3:0] DEVICE_ID  = 96'hC16B00000000_000004224000;

    typedef enum logic {ROW_ACCESS, ROW_CONFIG} t_row_op;

    // One line of the directed script: a register write or a bus access,
    // with the result word spelled out where it is obvious
    typedef struct packed {
        t_row_op     op;
        t_cfg_idx    idx;
        logic [23:0] value;
        logic        mode;
        logic [15:0] addr;
        logic [7:0]  wbyte;
        logic        known;
        t_result     want;
    } t_row;

    logic        i_clk = 1'b0;
    logic        i_rst_n;
    logic        i_s_axis_tvalid;
    logic        o_s_axis_tready;
    logic [23:0] i_s_axis_tdata;    // [15:0] bus_address, [23:16] write_byte
    logic        i_s_axis_tuser;    // [0] mode
    logic        o_m_axis_tvalid;
    logic        i_m_axis_tready = 1'b0;
    logic [39:0] o_m_axis_tdata;    // [7:0] read_byte, [8] board_finished,
                                    // [11:9] finished_slot, [35:12] finished_base,
                                    // [36] chain_complete, [39:37] zero
    logic        i_cfg_valid;
    logic        o_cfg_ready;
    logic [1:0]  i_cfg_index;
    logic [23:0] i_cfg_data;

    // Register copies and chain state of the predictor
    logic [3:0]  cfg_count;
    logic [23:0] cfg_kinds;
    logic [15:0] cfg_sizes;
    logic [15:0] cfg_mfr;
    logic [3:0]  chain_slot;
    logic [7:0]  ram_base [8];
    logic [7:0]  disk_base;
    logic [7:0]  ctrl_base;

    t_result     pending_words [$];
    t_row        script [$];
    logic        known_valid;
    t_result     known_word;
    int          fail_count = 0;
    int          tx_odds = 0;
    int          rx_odds = 0;
    int          rx_hold = 0;
    logic        calm = 1'b0;

    zorro2_autoconfig_chain_core uut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (i_s_axis_tvalid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_s_axis_tdata  (i_s_axis_tdata),
        .i_s_axis_tuser  (i_s_axis_tuser),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (i_m_axis_tready),
        .o_m_axis_tdata  (o_m_axis_tdata),
        .i_cfg_valid     (i_cfg_valid),
        .o_cfg_ready     (o_cfg_ready),
        .i_cfg_index     (i_cfg_index),
        .i_cfg_data      (i_cfg_data)
    );

    always #2 i_clk = ~i_clk;

    // ---------------------------------------------------------------
    // Predictor
    // ---------------------------------------------------------------

    // Counts above the chain limit act as the limit
    function automatic logic [3:0] live_count();
        return (cfg_count > 4'(MAX_BOARDS)) ? 4'(MAX_BOARDS) : cfg_count;
    endfunction

    // Unused kind codes and slots past the kind register read as empty
    function automatic t_kind slot_kind(input logic [3:0] slot);
        logic [2:0] raw;
        if (slot >= 4'd8)
            return KIND_NONE;
        raw = cfg_kinds[3*int'(slot) +: 3];
        if (raw > KIND_DEVICE)
            return KIND_NONE;
        return t_kind'(raw);
    endfunction

    function automatic logic has_base_reg(input t_kind kind);
        return kind == KIND_FASTRAM || kind == KIND_DISK || kind == KIND_DEVICE;
    endfunction

    // Work out the result word of one bus access and advance the chain state
    function automatic t_result chain_access(input logic mode, input logic [15:0] addr,
                                             input logic [7:0] wbyte);
        t_result    res;
        t_kind      kind;
        logic [3:0] nib;
        logic [7:0] base;
        logic       done;
        int         n;
        res  = '0;
        kind = slot_kind(chain_slot);
        nib  = 4'h0;
        base = 8'h00;
        done = 1'b0;
        n    = int'(addr >> 1);
        if (mode == MODE_READ) begin
            // Empty slots and a finished chain read plain zero
            if (chain_slot < live_count() && kind != KIND_NONE) begin
                if (!addr[0] && addr < 16'(2*ROM_NIBBLES)) begin
                    if (kind == KIND_FASTRAM && n == 1) begin
                        // Size nibble, with the link bit when a later board follows
                        case (cfg_sizes[2*int'(chain_slot) +: 2])
                            SIZE_64K: nib = 4'h1;
                            SIZE_2M:  nib = 4'h6;
                            SIZE_4M:  nib = 4'h7;
                            default:  nib = 4'h0;
                        endcase
                        if (int'(chain_slot) + 1 < int'(live_count()))
                            nib = nib | LINK_FLAG;
                    end else if (kind != KIND_BRIDGE && n >= 8 && n <= 11) begin
                        nib = cfg_mfr[4*(11-n) +: 4];
                    end else begin
                        case (kind)
                            KIND_FASTRAM: nib = FASTRAM_ID[n];
                            KIND_BRIDGE:  nib = BRIDGE_ID[n];
                            KIND_DISK:    nib = DISK_ID[n];
                            default:      nib = DEVICE_ID[n];
                        endcase
                    end
                end
                res.read_byte = {nib, 4'h0};
                // Only the four true-sense offsets come back uninverted
                if (addr != ADDR_TRUE_0 && addr != ADDR_TRUE_1 &&
                    addr != ADDR_TRUE_2 && addr != ADDR_TRUE_3)
                    res.read_byte = ~res.read_byte;
            end
        end else if (chain_slot < live_count()) begin
            case (kind)
                KIND_FASTRAM: base = ram_base[chain_slot[2:0]];
                KIND_DISK:    base = disk_base;
                KIND_DEVICE:  base = ctrl_base;
                default:      base = 8'h00;
            endcase
            // Boards without a base register finish on any write
            if (!has_base_reg(kind)) begin
                done = 1'b1;
            end else if (addr == ADDR_BASE_LO) begin
                base = {4'h0, wbyte[7:4]};
            end else if (addr == ADDR_BASE_HI) begin
                base = {wbyte[7:4], base[3:0]};
                done = 1'b1;
            end else if (addr == ADDR_SHUTUP) begin
                done = 1'b1;
            end
            case (kind)
                KIND_FASTRAM: ram_base[chain_slot[2:0]] = base;
                KIND_DISK:    disk_base = base;
                KIND_DEVICE:  ctrl_base = base;
                default:      ;
            endcase
            if (done) begin
                res.board_finished = 1'b1;
                res.finished_slot  = chain_slot[2:0];
                res.finished_base  = {base, 16'h0000};
                chain_slot         = chain_slot + 4'd1;
            end
        end
        // Writes past the end are dropped, so the slot index saturates
        res.chain_complete = chain_slot >= live_count();
        return res;
    endfunction

    // ---------------------------------------------------------------
    // Checking
    // ---------------------------------------------------------------

    task automatic note_failure(input string msg);
        if (fail_count < 10)
            $display("%0t ns: %s", $time, msg);
        fail_count++;
    endtask

    task automatic compare_word(input t_result want, input logic [39:0] raw);
        t_result got;
        got = raw[36:0];
        if (raw[39:37] !== 3'b000 ||
            got.read_byte      !== want.read_byte ||
            got.board_finished !== want.board_finished ||
            got.finished_slot  !== want.finished_slot ||
            got.finished_base  !== want.finished_base ||
            got.chain_complete !== want.chain_complete)
            note_failure($sformatf({"result mismatch: expected rd=%h fin=%b slot=%0d ",
                "base=%h done=%b, actual rd=%h fin=%b slot=%0d base=%h done=%b pad=%b"},
                want.read_byte, want.board_finished, want.finished_slot,
                want.finished_base, want.chain_complete, got.read_byte,
                got.board_finished, got.finished_slot, got.finished_base,
                got.chain_complete, raw[39:37]));
    endtask

    // Watch all three channels at the rising edge: queue the expected word of
    // each accepted access, then match each delivered word against the oldest
    always @(posedge i_clk) begin : watch
        t_result want;
        if (i_rst_n) begin
            if (i_cfg_valid && o_cfg_ready) begin
                case (i_cfg_index)
                    CFG_BOARD_COUNT: cfg_count = i_cfg_data[3:0];
                    CFG_BOARD_KINDS: cfg_kinds = i_cfg_data;
                    CFG_RAM_SIZES:   cfg_sizes = i_cfg_data[15:0];
                    default:         cfg_mfr   = i_cfg_data[15:0];
                endcase
            end
            if (i_s_axis_tvalid && o_s_axis_tready) begin
                want = chain_access(i_s_axis_tuser, i_s_axis_tdata[15:0],
                                    i_s_axis_tdata[23:16]);
                if (known_valid)
                    want = known_word;
                pending_words.push_back(want);
            end
            if (o_m_axis_tvalid && i_m_axis_tready) begin
                if (pending_words.size() == 0)
                    note_failure($sformatf("result word %h with nothing pending",
                                           o_m_axis_tdata));
                else
                    compare_word(pending_words.pop_front(), o_m_axis_tdata);
            end
        end
    end

    // Stall the result side at random in bursts; none while calm
    always @(negedge i_clk) begin
        if (rx_hold > 0) begin
            rx_hold <= rx_hold - 1;
            i_m_axis_tready <= 1'b0;
        end else if (!calm && rx_odds != 0 && $urandom_range(1, rx_odds) == 1) begin
            rx_hold <= $urandom_range(0, 18);
            i_m_axis_tready <= 1'b0;
        end else begin
            i_m_axis_tready <= 1'b1;
        end
    end

    // ---------------------------------------------------------------
    // Stimulus
    // ---------------------------------------------------------------

    function automatic t_result word_of(input logic [7:0] rd, input logic fin,
                                        input logic [2:0] slot, input logic [23:0] base,
                                        input logic done);
        t_result res;
        res.read_byte      = rd;
        res.board_finished = fin;
        res.finished_slot  = slot;
        res.finished_base  = base;
        res.chain_complete = done;
        return res;
    endfunction

    function automatic void add_cfg(input t_cfg_idx idx, input logic [23:0] value);
        t_row row;
        row       = '0;
        row.op    = ROW_CONFIG;
        row.idx   = idx;
        row.value = value;
        script.push_back(row);
    endfunction

    function automatic void add_access(input logic mode, input logic [15:0] addr,
                                       input logic [7:0] wbyte);
        t_row row;
        row       = '0;
        row.op    = ROW_ACCESS;
        row.mode  = mode;
        row.addr  = addr;
        row.wbyte = wbyte;
        script.push_back(row);
    endfunction

    function automatic void add_known(input logic mode, input logic [15:0] addr,
                                      input logic [7:0] wbyte, input t_result want);
        t_row row;
        row       = '0;
        row.op    = ROW_ACCESS;
        row.mode  = mode;
        row.addr  = addr;
        row.wbyte = wbyte;
        row.known = 1'b1;
        row.want  = want;
        script.push_back(row);
    endfunction

    // Mostly ROM offsets, some register offsets, some anywhere in the window
    function automatic logic [15:0] pick_address();
        case ($urandom_range(0, 9))
            0, 1: return 16'($urandom_range(0, 65535));
            2: begin
                case ($urandom_range(0, 6))
                    0:       return ADDR_TRUE_0;
                    1:       return ADDR_TRUE_1;
                    2:       return ADDR_TRUE_2;
                    3:       return ADDR_TRUE_3;
                    4:       return ADDR_BASE_LO;
                    5:       return ADDR_BASE_HI;
                    default: return ADDR_SHUTUP;
                endcase
            end
            default: return 16'($urandom_range(0, 2*ROM_NIBBLES + 7));
        endcase
    endfunction

    // Present one access word and hold it until the core takes it
    task automatic send_access(input logic mode, input logic [15:0] addr,
                               input logic [7:0] wbyte, input logic known,
                               input t_result want);
        if (!calm && tx_odds != 0 && $urandom_range(1, tx_odds) == 1) begin
            i_s_axis_tvalid = 1'b0;
            repeat ($urandom_range(1, 19)) @(negedge i_clk);
        end
        i_s_axis_tvalid = 1'b1;
        i_s_axis_tdata  = {wbyte, addr};
        i_s_axis_tuser  = mode;
        known_valid     = known;
        known_word      = want;
        do @(posedge i_clk); while (!o_s_axis_tready);
        @(negedge i_clk);
    endtask

    // Drop valid and hold until every pending result word has come back
    task automatic wait_drained();
        i_s_axis_tvalid = 1'b0;
        while (pending_words.size() != 0)
            @(negedge i_clk);
    endtask

    task automatic write_cfg(input t_cfg_idx idx, input logic [23:0] value);
        i_cfg_valid = 1'b1;
        i_cfg_index = idx;
        i_cfg_data  = value;
        do @(posedge i_clk); while (!o_cfg_ready);
        @(negedge i_clk);
        i_cfg_valid = 1'b0;
    endtask

    initial begin
        t_kind       kind;
        logic [15:0] addr;
        logic [23:0] kinds;
        logic [3:0]  last_slot;
        int          pick;
        int          on_board;

        i_rst_n         = 1'b0;
        i_s_axis_tvalid = 1'b0;
        i_s_axis_tdata  = '0;
        i_s_axis_tuser  = MODE_READ;
        i_cfg_valid     = 1'b0;
        i_cfg_index     = CFG_BOARD_COUNT;
        i_cfg_data      = '0;
        known_valid     = 1'b0;
        known_word      = '0;
        cfg_count       = '0;
        cfg_kinds       = '0;
        cfg_sizes       = '0;
        cfg_mfr         = '0;
        chain_slot      = '0;
        disk_base       = '0;
        ctrl_base       = '0;
        foreach (ram_base[i])
            ram_base[i] = '0;

        // Empty chain straight out of reset: reads give zero, writes drop
        add_cfg(CFG_BOARD_COUNT, 24'd0);
        add_known(MODE_READ, 16'h0000, 8'h00, word_of(8'h00, 0, 0, 24'h0, 1));
        add_known(MODE_WRITE, ADDR_BASE_HI, 8'hFF, word_of(8'h00, 0, 0, 24'h0, 1));
        // Three boards: fast RAM (8MB, linked), bridge, disk controller
        add_cfg(CFG_MFR_ID, 24'h001234);
        add_cfg(CFG_RAM_SIZES, {22'h0, SIZE_8M});
        add_cfg(CFG_BOARD_KINDS, {15'h0, KIND_DISK, KIND_BRIDGE, KIND_FASTRAM});
        add_cfg(CFG_BOARD_COUNT, 24'd3);
        add_known(MODE_READ, ADDR_TRUE_0, 8'h00, word_of(8'hE0, 0, 0, 24'h0, 0));
        add_known(MODE_READ, ADDR_TRUE_1, 8'h00, word_of(8'h80, 0, 0, 24'h0, 0));
        add_access(MODE_READ, 16'h0010, 8'h00);
        add_access(MODE_READ, 16'h002E, 8'h00);
        add_known(MODE_READ, 16'h0001, 8'h00, word_of(8'hFF, 0, 0, 24'h0, 0));
        add_access(MODE_READ, 16'h0030, 8'h00);
        add_known(MODE_READ, ADDR_TRUE_2, 8'h00, word_of(8'h00, 0, 0, 24'h0, 0));
        add_access(MODE_READ, ADDR_TRUE_3, 8'h00);
        add_access(MODE_READ, 16'hFFFF, 8'hFF);
        add_known(MODE_WRITE, ADDR_BASE_LO, 8'hFF, word_of(8'h00, 0, 0, 24'h0, 0));
        add_access(MODE_WRITE, 16'h0050, 8'h5A);
        add_known(MODE_WRITE, ADDR_BASE_HI, 8'hA5, word_of(8'h00, 1, 0, 24'hAF0000, 0));
        add_access(MODE_READ, ADDR_TRUE_0, 8'h00);
        add_access(MODE_READ, 16'h0012, 8'h00);
        add_known(MODE_WRITE, 16'h0000, 8'h00, word_of(8'h00, 1, 1, 24'h0, 0));
        add_access(MODE_READ, 16'h0006, 8'h00);
        add_access(MODE_WRITE, ADDR_BASE_LO, 8'h30);
        add_known(MODE_WRITE, ADDR_SHUTUP, 8'h00, word_of(8'h00, 1, 2, 24'h030000, 1));
        add_known(MODE_READ, ADDR_TRUE_0, 8'h00, word_of(8'h00, 0, 0, 24'h0, 1));
        add_known(MODE_WRITE, ADDR_BASE_HI, 8'hFF, word_of(8'h00, 0, 0, 24'h0, 1));
        // Fourth slot with an unused kind code: reads zero, any write finishes it
        add_cfg(CFG_BOARD_KINDS, 24'hFFFFFF);
        add_cfg(CFG_RAM_SIZES, 24'h00FFFF);
        add_cfg(CFG_MFR_ID, 24'h00FFFF);
        add_cfg(CFG_BOARD_COUNT, 24'd4);
        add_known(MODE_READ, ADDR_TRUE_0, 8'h00, word_of(8'h00, 0, 0, 24'h0, 0));
        add_known(MODE_WRITE, ADDR_TRUE_3, 8'hFF, word_of(8'h00, 1, 3, 24'h0, 1));

        repeat (6) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        foreach (script[i]) begin
            if (script[i].op == ROW_CONFIG) begin
                wait_drained();
                write_cfg(script[i].idx, script[i].value);
            end else begin
                send_access(script[i].mode, script[i].addr, script[i].wbyte,
                            script[i].known, script[i].want);
            end
        end
        known_valid = 1'b0;

        // Walk the rest of the chain one phase at a time. Each phase opens
        // the next board (or two, or the whole tail) with fresh register
        // contents, reads its ROM, pokes its base register and finishes it.
        last_slot = chain_slot;
        on_board  = 0;
        while (chain_slot < 4'd8) begin
            wait_drained();
            tx_odds = 4 * $urandom_range(0, 3);
            rx_odds = 4 * $urandom_range(0, 3);
            kinds = '0;
            for (int s = 0; s < 8; s++)
                kinds[3*s +: 3] = ($urandom_range(0, 5) == 0) ? 3'($urandom_range(0, 7)) :
                                  3'($urandom_range(KIND_FASTRAM, KIND_DEVICE));
            write_cfg(CFG_BOARD_KINDS, kinds);
            write_cfg(CFG_RAM_SIZES, 24'($urandom_range(0, 65535)));
            write_cfg(CFG_MFR_ID, 24'($urandom_range(0, 65535)));
            write_cfg(CFG_BOARD_COUNT, (chain_slot >= 4'd6) ? 24'd15 :
                      24'(chain_slot) + 24'd1 + 24'($urandom_range(0, 1)));
            while (chain_slot < live_count()) begin
                kind = slot_kind(chain_slot);
                if (chain_slot != last_slot) begin
                    last_slot = chain_slot;
                    on_board  = 0;
                end
                on_board++;
                pick = $urandom_range(0, 399);
                if (pick == 0 || on_board > 800) begin
                    // Finish the board
                    if (has_base_reg(kind))
                        addr = ($urandom_range(0, 1) == 0) ? ADDR_BASE_HI : ADDR_SHUTUP;
                    else
                        addr = pick_address();
                    send_access(MODE_WRITE, addr, 8'($urandom), 1'b0, '0);
                end else if (pick < 80 && has_base_reg(kind)) begin
                    // Base low nibble or a stray write that must not finish
                    addr = ($urandom_range(0, 3) != 0) ? ADDR_BASE_LO : pick_address();
                    if (addr == ADDR_BASE_HI || addr == ADDR_SHUTUP)
                        addr = ADDR_BASE_LO;
                    send_access(MODE_WRITE, addr, 8'($urandom), 1'b0, '0);
                end else begin
                    send_access(MODE_READ, pick_address(), 8'($urandom), 1'b0, '0);
                end
            end
            // Poke the finished chain for a while
            repeat ($urandom_range(5, 20))
                send_access(1'($urandom_range(MODE_READ, MODE_WRITE)), pick_address(),
                            8'($urandom), 1'b0, '0);
        end

        // Saturated chain with the count above the limit; no idling from here
        wait_drained();
        calm = 1'b1;
        write_cfg(CFG_BOARD_KINDS, 24'h000000);
        write_cfg(CFG_RAM_SIZES, 24'h000000);
        write_cfg(CFG_MFR_ID, 24'h000000);
        write_cfg(CFG_BOARD_COUNT, 24'd15);
        repeat (400)
            send_access(1'($urandom_range(MODE_READ, MODE_WRITE)), pick_address(),
                        8'($urandom), 1'b0, '0);

        wait_drained();
        // Leave room for any stray word to show up
        repeat (8) @(posedge i_clk);
        if (fail_count == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

    initial begin
        #4_000_000;
        $display("CHECKS FAILED");
        $finish;
    end

endmodule
